// ===== hw/rtl/hdit_pkg.sv =====
// Shared types and constants of the periodic task slot table.
package hdit_pkg;

  // A tick yields at most this many run results.
  localparam int unsigned MAX_RUNS = 8;
  localparam int unsigned RUN_W    = 4;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REG  = 2'd1,
    OP_REM  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN         = 3'd0,
    ST_REGISTERED  = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_NOTHING_DUE = 3'd5
  } status_e;

  // One classified input beat as it waits in the queue.
  typedef struct packed {
    op_e         op;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [7:0]  handle;
    logic [15:0] hour_rate;
    logic [15:0] day_rate;
  } item_t;

  // Contents of one table slot.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [4:0]  last_hour;
    logic [4:0]  last_day;
    logic [15:0] hour_rate;
    logic [15:0] day_rate;
  } slot_t;

  // One result beat.
  typedef struct packed {
    status_e    status;
    logic [7:0] task_id;
    logic [4:0] hour;
    logic [2:0] slot;
    logic       last;
  } res_t;

endpackage

// ===== hw/rtl/hour_day_interval_task_table.sv =====
// Top level of the periodic task slot table.
//
//  Channel | Direction | Handshake              | Beat fields
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i, in_stall_o | opcode, current hour/day, handle, rates
//  out     | output    | out_valid_o, out_stall_i | status, task, hour, slot, last flag
//
// An item leaves the queue, has up to SLOTS slots walked in the back end, and then
// hands over its final result. The slot memory has one write and one read port.
// The walk reads one slot per cycle, unless a stalled output holds it.
// Reset clears the slot valid bits at once; the block takes beats right after reset.
// A stalled output holds the walk only when a second result is ready to go out.
// Two queued items let the input side keep accepting while a walk is under way.
module hour_day_interval_task_table import hdit_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  current_hour_i,
  input  logic [4:0]  current_day_i,
  input  logic [7:0]  task_handle_i,
  input  logic [15:0] hour_interval_i,
  input  logic [15:0] day_interval_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  run_task_o,
  output logic [4:0]  run_hour_o,
  output logic [2:0]  slot_index_o,
  output logic        last_result_o
);

  logic  item_valid;
  item_t item;
  logic  pop;

  // Accept and queue.
  hdit_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .current_hour_i  (current_hour_i),
    .current_day_i   (current_day_i),
    .task_handle_i   (task_handle_i),
    .hour_interval_i (hour_interval_i),
    .day_interval_i  (day_interval_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .pop_i           (pop)
  );

  // Walk the table and produce results.
  hdit_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .run_task_o    (run_task_o),
    .run_hour_o    (run_hour_o),
    .slot_index_o  (slot_index_o),
    .last_result_o (last_result_o)
  );

endmodule

// ===== hw/rtl/hdit_front.sv =====
// Front end: accepts input beats, drops unused opcodes and queues the rest.
module hdit_front import hdit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  current_hour_i,
  input  logic [4:0]  current_day_i,
  input  logic [7:0]  task_handle_i,
  input  logic [15:0] hour_interval_i,
  input  logic [15:0] day_interval_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        pop_i
);

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  item_t            q_mem [QDEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;
  item_t            in_item;

  // Classify the incoming beat.
  always_comb begin
    in_item.op        = op_e'(opcode_i);
    in_item.hour      = current_hour_i;
    in_item.day       = current_day_i;
    in_item.handle    = task_handle_i;
    in_item.hour_rate = hour_interval_i;
    in_item.day_rate  = day_interval_i;
  end

  assign in_stall_o   = (count_q == CntW'(QDEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = q_mem[rd_ptr_q];

  // A beat with the unused opcode is taken and then dropped.
  assign push = in_valid_i && !in_stall_o && (in_item.op != OP_NONE);
  assign pop  = pop_i && item_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ===== hw/rtl/hdit_back.sv =====
// Back end: walks the slot table for each queued item and drives result beats.
module hdit_back import hdit_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  run_task_o,
  output logic [4:0]  run_hour_o,
  output logic [2:0]  slot_index_o,
  output logic        last_result_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [RUN_W-1:0]  runs_q, runs_d;
  logic              pend_valid_q, pend_valid_d;
  res_t              pend_q, pend_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  slot_t             mem [SLOTS];
  slot_t             rd_q;
  slot_t             wdata;
  logic              we;

  logic              out_free;
  logic              at_end;
  logic              cur_valid;
  logic [5:0]        dh, dd;
  logic              due;
  logic [2:0]        cur_slot;
  res_t              miss;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign at_end    = (idx_q == IdxW'(SLOTS - 1));
  assign cur_valid = valid_q[idx_q];
  assign cur_slot  = 3'(idx_q);

  // Signed hour and day differences against the slot's rates.
  assign dh  = {1'b0, item_q.hour} - {1'b0, rd_q.last_hour};
  assign dd  = {1'b0, item_q.day} - {1'b0, rd_q.last_day};
  assign due = !dh[5] && ({11'd0, dh[4:0]} >= rd_q.hour_rate) &&
               !dd[5] && ({11'd0, dd[4:0]} >= rd_q.day_rate);

  // Result when the walk found nothing.
  always_comb begin
    miss.task_id = item_q.handle;
    miss.hour    = '0;
    miss.slot    = '0;
    miss.last    = 1'b1;
    unique case (item_q.op)
      OP_TICK: begin
        miss.status  = ST_NOTHING_DUE;
        miss.task_id = '0;
      end
      OP_REG:  miss.status = ST_TABLE_FULL;
      OP_REM:  miss.status = ST_NOT_FOUND;
      default: miss.status = ST_NOT_FOUND;
    endcase
  end

  // Walk sequencer.
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    runs_d       = runs_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    valid_d      = valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    pop_o        = 1'b0;
    we           = 1'b0;
    wdata        = rd_q;

    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (item_valid_i) begin
          pop_o        = 1'b1;
          item_d       = item_i;
          runs_d       = '0;
          pend_valid_d = 1'b0;
          state_d      = S_WALK;
        end
      end

      S_WALK: begin
        unique case (item_q.op)
          OP_TICK: begin
            if (cur_valid && due) begin
              // The previous run is not the last one; pass it on first.
              if (!pend_valid_q || out_free) begin
                if (pend_valid_q) begin
                  out_d       = pend_q;
                  out_valid_d = 1'b1;
                end
                we              = 1'b1;
                wdata.last_hour = item_q.hour;
                wdata.last_day  = item_q.day;
                pend_valid_d    = 1'b1;
                pend_d.status   = ST_RUN;
                pend_d.task_id  = rd_q.task_id;
                pend_d.hour     = item_q.hour;
                pend_d.slot     = cur_slot;
                pend_d.last     = 1'b0;
                runs_d          = runs_q + 1'b1;
                if (at_end || (runs_q == RUN_W'(MAX_RUNS - 1))) begin
                  state_d = S_FINISH;
                end else begin
                  idx_d = idx_q + 1'b1;
                end
              end
            end else if (at_end) begin
              state_d = S_FINISH;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          OP_REG: begin
            if (!cur_valid) begin
              we              = 1'b1;
              wdata.task_id   = item_q.handle;
              wdata.last_hour = item_q.hour;
              wdata.last_day  = '0;
              wdata.hour_rate = item_q.hour_rate;
              wdata.day_rate  = item_q.day_rate;
              valid_d[idx_q]  = 1'b1;
              pend_valid_d    = 1'b1;
              pend_d.status   = ST_REGISTERED;
              pend_d.task_id  = item_q.handle;
              pend_d.hour     = item_q.hour;
              pend_d.slot     = cur_slot;
              pend_d.last     = 1'b0;
              state_d         = S_FINISH;
            end else if (at_end) begin
              state_d = S_FINISH;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          default: begin
            if (cur_valid && (rd_q.task_id == item_q.handle)) begin
              valid_d[idx_q] = 1'b0;
              pend_valid_d   = 1'b1;
              pend_d.status  = ST_REMOVED;
              pend_d.task_id = item_q.handle;
              pend_d.hour    = '0;
              pend_d.slot    = cur_slot;
              pend_d.last    = 1'b0;
              state_d        = S_FINISH;
            end else if (at_end) begin
              state_d = S_FINISH;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        endcase
      end

      S_FINISH: begin
        // The held result, or the miss result, closes the item.
        if (out_free) begin
          out_d       = pend_valid_q ? pend_q : miss;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          idx_d       = '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      runs_q       <= '0;
      pend_valid_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      runs_q       <= runs_d;
      pend_valid_q <= pend_valid_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Slot memory: one write at the current slot, one registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[idx_d];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign run_task_o    = out_q.task_id;
  assign run_hour_o    = out_q.hour;
  assign slot_index_o  = out_q.slot;
  assign last_result_o = out_q.last;

endmodule

// ===== verif/tb_hour_day_interval_task_table.sv =====
// Self-checking testbench of the periodic task slot table, with a driver, a monitor and a predictor.
module tb_hour_day_interval_task_table;
  import hdit_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned RAND_BEATS  = 356;
  localparam int unsigned HOLD_AT     = 40;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned TAIL_CYCLES = SLOTS + 6;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // A queued input beat; hold_for_drain keeps it back until no result is owed.
  typedef struct {
    item_t body;
    bit    hold_for_drain;
  } pending_beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i        = OP_NONE;
  logic [4:0]  current_hour_i  = '0;
  logic [4:0]  current_day_i   = '0;
  logic [7:0]  task_handle_i   = '0;
  logic [15:0] hour_interval_i = '0;
  logic [15:0] day_interval_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  run_task_o;
  logic [4:0]  run_hour_o;
  logic [2:0]  slot_index_o;
  logic        last_result_o;

  pending_beat_t beat_backlog[$];
  res_t          owed_results[$];
  pending_beat_t next_beat;
  item_t         on_wire;
  res_t          want;

  // Mirror of the slot table as the block should hold it.
  logic  slot_used[SLOTS];
  slot_t slot_mem[SLOTS];

  int unsigned total_beats = 0;
  int unsigned sent_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned run_cnt     = 0;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned op_seen[4]  = '{0, 0, 0, 0};

  hour_day_interval_task_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .current_hour_i (current_hour_i),
    .current_day_i  (current_day_i),
    .task_handle_i  (task_handle_i),
    .hour_interval_i(hour_interval_i),
    .day_interval_i (day_interval_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .run_task_o     (run_task_o),
    .run_hour_o     (run_hour_o),
    .slot_index_o   (slot_index_o),
    .last_result_o  (last_result_o)
  );

  // Free-running clock and cycle count.
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Pacing: the first third idles the sender lightly and stalls the receiver hard,
  // the second third swaps the two, and the last third runs at full speed.
  function automatic int unsigned pace_phase();
    if (sent_cnt * 3 < total_beats) return 0;
    if (sent_cnt * 3 < total_beats * 2) return 1;
    return 2;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (pace_phase())
      0: return 18;
      1: return 73;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (pace_phase())
      0: return 73;
      1: return 18;
      default: return 0;
    endcase
  endfunction

  function automatic res_t make_result(status_e st, logic [7:0] id, logic [4:0] hr,
                                       logic [2:0] slot, logic last);
    res_t r;
    r.status  = st;
    r.task_id = id;
    r.hour    = hr;
    r.slot    = slot;
    r.last    = last;
    return r;
  endfunction

  // Apply one accepted beat to the mirrored table and queue the results it owes.
  task automatic apply_table_op(input item_t it);
    res_t runs[MAX_RUNS];
    int   n;
    int   dh;
    int   dd;
    bit   done;
    n    = 0;
    done = 1'b0;
    op_seen[it.op] = op_seen[it.op] + 1;
    case (it.op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (n < MAX_RUNS && slot_used[i]) begin
            dh = int'(it.hour) - int'(slot_mem[i].last_hour);
            dd = int'(it.day) - int'(slot_mem[i].last_day);
            if (dh >= int'(slot_mem[i].hour_rate) && dd >= int'(slot_mem[i].day_rate)) begin
              runs[n] = make_result(ST_RUN, slot_mem[i].task_id, it.hour, 3'(i), 1'b0);
              n = n + 1;
              slot_mem[i].last_hour = it.hour;
              slot_mem[i].last_day  = it.day;
            end
          end
        end
        if (n == 0) begin
          owed_results.push_back(make_result(ST_NOTHING_DUE, '0, '0, '0, 1'b1));
        end else begin
          runs[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) owed_results.push_back(runs[k]);
          run_cnt = run_cnt + n;
        end
      end
      OP_REG: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !slot_used[i]) begin
            done                  = 1'b1;
            slot_used[i]          = 1'b1;
            slot_mem[i].task_id   = it.handle;
            slot_mem[i].last_hour = it.hour;
            slot_mem[i].last_day  = '0;
            slot_mem[i].hour_rate = it.hour_rate;
            slot_mem[i].day_rate  = it.day_rate;
            owed_results.push_back(make_result(ST_REGISTERED, it.handle, it.hour, 3'(i),
                                               1'b1));
          end
        end
        if (!done) owed_results.push_back(make_result(ST_TABLE_FULL, it.handle, '0, '0, 1'b1));
      end
      OP_REM: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && slot_used[i] && slot_mem[i].task_id == it.handle) begin
            done         = 1'b1;
            slot_used[i] = 1'b0;
            slot_mem[i]  = '{task_id: slot_mem[i].task_id, default: '0};
            owed_results.push_back(make_result(ST_REMOVED, it.handle, '0, 3'(i), 1'b1));
          end
        end
        if (!done) owed_results.push_back(make_result(ST_NOT_FOUND, it.handle, '0, '0, 1'b1));
      end
      default: begin
        // The unused opcode leaves the table alone and owes nothing.
      end
    endcase
  endtask

  task automatic queue_beat(input op_e op, input logic [4:0] hr, input logic [4:0] dy,
                            input logic [7:0] id, input logic [15:0] hrate,
                            input logic [15:0] drate, input bit drain);
    pending_beat_t p;
    p.body.op        = op;
    p.body.hour      = hr;
    p.body.day       = dy;
    p.body.handle    = id;
    p.body.hour_rate = hrate;
    p.body.day_rate  = drate;
    p.hold_for_drain = drain;
    beat_backlog.push_back(p);
  endtask

  // Driver: predicts on each accepted beat and offers the next one when the slot frees.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_table_op(on_wire);
        sent_cnt = sent_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (beat_backlog.size() != 0 &&
            !(beat_backlog[0].hold_for_drain && owed_results.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct()) begin
          next_beat        = beat_backlog.pop_front();
          on_wire          = next_beat.body;
          opcode_i        <= on_wire.op;
          current_hour_i  <= on_wire.hour;
          current_day_i   <= on_wire.day;
          task_handle_i   <= on_wire.handle;
          hour_interval_i <= on_wire.hour_rate;
          day_interval_i  <= on_wire.day_rate;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest owed result and paces the stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt = result_cnt + 1;
        if (owed_results.size() == 0) begin
          err_cnt = err_cnt + 1;
          $display("%0t: unexpected result beat status %0d task %0d hour %0d slot %0d last %0d",
                   $time, status_o, run_task_o, run_hour_o, slot_index_o, last_result_o);
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status) begin
            err_cnt = err_cnt + 1;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          end
          if (run_task_o !== want.task_id) begin
            err_cnt = err_cnt + 1;
            $display("%0t: run_task expected %0d actual %0d", $time, want.task_id, run_task_o);
          end
          if (run_hour_o !== want.hour) begin
            err_cnt = err_cnt + 1;
            $display("%0t: run_hour expected %0d actual %0d", $time, want.hour, run_hour_o);
          end
          if (slot_index_o !== want.slot) begin
            err_cnt = err_cnt + 1;
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, slot_index_o);
          end
          if (last_result_o !== want.last) begin
            err_cnt = err_cnt + 1;
            $display("%0t: last_result expected %0d actual %0d", $time, want.last,
                     last_result_o);
          end
        end
      end
      // One long hold-off early on lets the block back up into its input.
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left    = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct());
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    op_e         op;
    logic [4:0]  hr;
    logic [4:0]  dy;
    logic [7:0]  id;
    logic [15:0] hrate;
    logic [15:0] drate;

    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_mem[i]  = '0;
    end

    // Directed: empty table, fill to full, overflow, extremes of the clock fields,
    // the unused opcode, removal of first match and reuse of a freed slot.
    queue_beat(OP_TICK, 5'd0, 5'd1, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REM, 5'd0, 5'd1, 8'd255, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REG, 5'd0, 5'd1, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REG, 5'd23, 5'd31, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int k = 1; k <= 6; k++) queue_beat(OP_REG, 5'd5, 5'd2, 8'(k), 16'(k), 16'd0, 1'b0);
    queue_beat(OP_REG, 5'd7, 5'd3, 8'd99, 16'd1, 16'd1, 1'b0);
    queue_beat(OP_TICK, 5'd23, 5'd31, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_TICK, 5'd31, 5'd0, 8'd0, 16'd0, 16'd0, 1'b1);
    queue_beat(OP_NONE, 5'd31, 5'd31, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_beat(OP_REM, 5'd0, 5'd1, 8'd255, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REM, 5'd0, 5'd1, 8'd255, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REG, 5'd12, 5'd15, 8'd3, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REM, 5'd0, 5'd1, 8'd3, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_TICK, 5'd0, 5'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_TICK, 5'd24, 5'd16, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REM, 5'd0, 5'd1, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_beat(OP_REG, 5'd31, 5'd31, 8'd170, 16'h5555, 16'hAAAA, 1'b0);
    queue_beat(OP_TICK, 5'd31, 5'd31, 8'd0, 16'd0, 16'd0, 1'b0);

    // Random: mostly a small handle pool so that removes hit, mostly short rates so
    // that ticks run tasks, with occasional full-range values and drain points.
    for (int k = 0; k < RAND_BEATS; k++) begin
      pick  = $urandom_range(0, 99);
      op    = (pick < 40) ? OP_TICK : (pick < 70) ? OP_REG : (pick < 95) ? OP_REM : OP_NONE;
      hr    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
      dy    = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
      id    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
      hrate = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      drate = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      queue_beat(op, hr, dy, id, hrate, drate, $urandom_range(0, 49) == 0);
    end
    total_beats = beat_backlog.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_backlog.size() != 0 || in_valid_i || owed_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d beats: %0d ticks, %0d registers, %0d removes, %0d unused opcodes.",
             sent_cnt, op_seen[OP_TICK], op_seen[OP_REG], op_seen[OP_REM], op_seen[OP_NONE]);
    $display("Checked %0d result beats, %0d of them task runs, with %0d mismatches.",
             result_cnt, run_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
